// ===== rtl/core/gray4_pkg.sv =====
// Shared types and constants of the RGB565 to 4-bit gray row packer.
`timescale 1ns / 1ps

package gray4_pkg;

   // Panel geometry used for the rotated row and column addresses.
   localparam int PANEL_WIDTH  = 256;
   localparam int PANEL_HEIGHT = 64;

   // Field widths.
   localparam int PIXEL_W  = 16;
   localparam int WORD_W   = 32;
   localparam int COUNT_W  = 3;
   localparam int CSR_W    = 8;
   localparam int ROW_W    = 6;
   localparam int COL_W    = 8;
   localparam int CSR_IDX_W = 2;

   // Line memory geometry: 128 packed bytes held as 32 words of 4 bytes.
   localparam int MEM_DEPTH  = 32;
   localparam int MEM_ADDR_W = 5;

   // Luma weights.
   localparam logic [7:0] WEIGHT_R = 8'd77;
   localparam logic [7:0] WEIGHT_G = 8'd150;
   localparam logic [7:0] WEIGHT_B = 8'd29;

   // Command word bytes.
   localparam logic [7:0] CMD_ROW_ADDR = 8'hB0;
   localparam logic [7:0] CMD_COL_HIGH = 8'h10;

   // Full byte count of a data or command word.
   localparam logic [COUNT_W-1:0] FULL_COUNT = 3'd4;

   // Panel-relative constants for the rotated addresses.
   localparam logic [15:0] PANEL_X_MAX = 16'(PANEL_WIDTH - 1);
   localparam logic [7:0]  PANEL_Y_MAX = 8'(PANEL_HEIGHT - 1);

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_FIRST = 2'd0,
      CSR_X_LAST  = 2'd1,
      CSR_Y_FIRST = 2'd2,
      CSR_Y_LAST  = 2'd3
   } csr_index_type;

   // Control states of the packer.
   typedef enum logic [2:0] {
      ST_PIXEL = 3'b001,
      ST_CMD   = 3'b010,
      ST_DATA  = 3'b100
   } state_type;

   // Keeps the top bytes of a word that hold valid data, zeroes the rest.
   function automatic logic [WORD_W-1:0] keep_bytes(input logic [COUNT_W-1:0] count);
      logic [WORD_W-1:0] mask;
      case (count)
         3'd1:    mask = 32'hFF00_0000;
         3'd2:    mask = 32'hFFFF_0000;
         3'd3:    mask = 32'hFFFF_FF00;
         default: mask = 32'hFFFF_FFFF;
      endcase
      return mask;
   endfunction

endpackage

// ===== rtl/core/rgb565_gray4_rotated_row_packer_core.sv =====
// Top level of the RGB565 to 4-bit gray rotated row packer.
`timescale 1ns / 1ps

// The block takes the RGB565 pixels of the configured area in row-major order, one per
// cycle, turns each into a 4-bit luma nibble and packs the row in reversed order, two
// pixels per byte, into a line memory of 32 words by 4 bytes. On the last pixel of a row
// the input stalls while the row drains: one command transaction (rotated row and column
// address) and then ceil(w/8) data transactions of up to four bytes, where w is the row
// width in pixels. The drain is served by the single read port of the line memory, which
// delivers one word per cycle while the result side does not stall. A configuration
// write restarts the area at its top row and drops a partly received row.
module rgb565_gray4_rotated_row_packer_core (
   input  logic                           clock,
   input  logic                           reset,
   // Configuration port.
   input  logic                           csr_we,
   input  logic [gray4_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gray4_pkg::CSR_W-1:0]    csr_wdata,
   // Pixel input channel.
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [gray4_pkg::PIXEL_W-1:0]  req_pixel,
   // Result channel.
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [gray4_pkg::WORD_W-1:0]   rsp_out_word,
   output logic [gray4_pkg::COUNT_W-1:0]  rsp_byte_count,
   output logic                           rsp_is_command,
   output logic                           rsp_row_end,
   output logic                           rsp_area_end
);
   import gray4_pkg::*;

   // Configuration registers.
   logic [COL_W-1:0] x_first_ff;
   logic [COL_W-1:0] x_last_ff;
   logic [ROW_W-1:0] y_first_ff;
   logic [ROW_W-1:0] y_last_ff;

   // Control state.
   state_type              state_ff, state_in;
   logic [COL_W-1:0]       column_ff, column_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [MEM_ADDR_W-1:0]  word_ff, word_in;
   logic                   last_row_ff, last_row_in;
   logic [3:0]             low_nib_ff;

   // Line memory and its registered read data.
   logic [WORD_W-1:0]      line_mem_ff [MEM_DEPTH];
   logic [WORD_W-1:0]      rd_data_ff;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]      out_word_ff, out_word_in;
   logic [COUNT_W-1:0]     byte_count_ff, byte_count_in;
   logic                   is_command_ff, is_command_in;
   logic                   row_end_ff, row_end_in;
   logic                   area_end_ff, area_end_in;

   // Effective area bounds.
   logic [COL_W-1:0]  eff_xf;
   logic [COL_W-1:0]  eff_xl;
   logic [COL_W-1:0]  span;
   logic [ROW_W-1:0]  eff_yl;
   logic              at_last_row;

   // Pixel path.
   logic              pixel_accept;
   logic              row_done;
   logic [7:0]        red8, green8, blue8;
   logic [15:0]       luma_sum;
   logic [3:0]        nib;
   logic [COL_W-1:0]  byte_pos;
   logic              mem_we;
   logic [MEM_ADDR_W-1:0] wr_word;
   logic [1:0]        wr_lane;

   // Drain path.
   logic              out_free;
   logic              last_word;
   logic [COUNT_W-1:0] data_count;
   logic [15:0]       col_diff;
   logic [7:0]        col_addr;
   logic [7:0]        prow;

   // Area bounds with the forced column parity and the inverted-range fixes.
   always_comb begin
      eff_xf = {x_first_ff[COL_W-1:1], 1'b0};
      eff_xl = {x_last_ff[COL_W-1:1], 1'b1};
      if (eff_xl < eff_xf) begin
         eff_xl = eff_xf + 8'd1;
      end
      span   = eff_xl - eff_xf;
      eff_yl = (y_last_ff < y_first_ff) ? y_first_ff : y_last_ff;
   end

   assign at_last_row = (row_ff >= eff_yl);

   // Luma of the incoming pixel, reduced to a nibble; the products are formed at 16 bits.
   always_comb begin
      red8     = {req_pixel[15:11], req_pixel[15:13]};
      green8   = {req_pixel[10:5], req_pixel[10:9]};
      blue8    = {req_pixel[4:0], req_pixel[4:2]};
      luma_sum = 16'(red8) * 16'(WEIGHT_R) + 16'(green8) * 16'(WEIGHT_G)
                 + 16'(blue8) * 16'(WEIGHT_B);
      nib      = luma_sum[15:12];
   end

   assign req_stall    = (state_ff != ST_PIXEL);
   assign pixel_accept = req_valid && !req_stall;
   assign row_done     = (column_ff == span);

   // The pair of pixels of one byte arrives back to back: the near pixel is held and
   // the whole byte is written with the far pixel in the high nibble.
   always_comb begin
      byte_pos = span - column_ff;
      wr_word  = byte_pos[7:3];
      wr_lane  = byte_pos[2:1];
      mem_we   = pixel_accept && column_ff[0];
   end

   always_ff @(posedge clock) begin
      if (pixel_accept && !column_ff[0]) begin
         low_nib_ff <= nib;
      end
      if (mem_we) begin
         line_mem_ff[wr_word][{~wr_lane, 3'b000} +: 8] <= {nib, low_nib_ff};
      end
      rd_data_ff <= line_mem_ff[word_in];
   end

   // Rotated addresses for the command word.
   always_comb begin
      col_diff = PANEL_X_MAX - {8'd0, eff_xl};
      col_addr = col_diff[8:1];
      prow     = PANEL_Y_MAX - {2'd0, row_ff};
   end

   // Data word bookkeeping.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last_word  = (word_ff == span[7:3]);
   assign data_count = last_word ? COUNT_W'({1'b0, span[2:1]} + 3'd1) : FULL_COUNT;

   // Sequencer: receive a row, then send the command and the packed words.
   always_comb begin
      state_in      = state_ff;
      column_in     = column_ff;
      row_in        = row_ff;
      word_in       = word_ff;
      last_row_in   = last_row_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      out_word_in   = out_word_ff;
      byte_count_in = byte_count_ff;
      is_command_in = is_command_ff;
      row_end_in    = row_end_ff;
      area_end_in   = area_end_ff;

      case (state_ff)
         ST_PIXEL: begin
            if (pixel_accept) begin
               if (row_done) begin
                  column_in = '0;
                  word_in   = '0;
                  state_in  = ST_CMD;
               end else begin
                  column_in = column_ff + 8'd1;
               end
            end
         end
         ST_CMD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_word_in   = {CMD_ROW_ADDR, prow, 4'h0, col_addr[3:0],
                                CMD_COL_HIGH | {4'h0, col_addr[7:4]}};
               byte_count_in = FULL_COUNT;
               is_command_in = 1'b1;
               row_end_in    = 1'b0;
               area_end_in   = 1'b0;
               last_row_in   = at_last_row;
               row_in        = at_last_row ? y_first_ff : row_ff + 6'd1;
               state_in      = ST_DATA;
            end
         end
         ST_DATA: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_word_in   = rd_data_ff & keep_bytes(data_count);
               byte_count_in = data_count;
               is_command_in = 1'b0;
               row_end_in    = last_word;
               area_end_in   = last_word && last_row_ff;
               if (last_word) begin
                  state_in = ST_PIXEL;
               end else begin
                  word_in = word_ff + 5'd1;
               end
            end
         end
         default: begin
            state_in = ST_PIXEL;
         end
      endcase

      // Any register write restarts the area.
      if (csr_we) begin
         column_in = '0;
         case (csr_index)
            CSR_Y_FIRST: row_in = csr_wdata[ROW_W-1:0];
            default:     row_in = y_first_ff;
         endcase
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_first_ff <= 8'd0;
         x_last_ff  <= 8'd255;
         y_first_ff <= 6'd0;
         y_last_ff  <= 6'd63;
      end else if (csr_we) begin
         case (csr_index)
            CSR_X_FIRST: x_first_ff <= csr_wdata;
            CSR_X_LAST:  x_last_ff  <= csr_wdata;
            CSR_Y_FIRST: y_first_ff <= csr_wdata[ROW_W-1:0];
            CSR_Y_LAST:  y_last_ff  <= csr_wdata[ROW_W-1:0];
            default:     x_first_ff <= x_first_ff;
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_PIXEL;
         column_ff    <= '0;
         row_ff       <= '0;
         word_ff      <= '0;
         last_row_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         word_ff      <= word_in;
         last_row_ff  <= last_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload registers.
   always_ff @(posedge clock) begin
      out_word_ff   <= out_word_in;
      byte_count_ff <= byte_count_in;
      is_command_ff <= is_command_in;
      row_end_ff    <= row_end_in;
      area_end_ff   <= area_end_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_word   = out_word_ff;
   assign rsp_byte_count = byte_count_ff;
   assign rsp_is_command = is_command_ff;
   assign rsp_row_end    = row_end_ff;
   assign rsp_area_end   = area_end_ff;

endmodule

// ===== rtl/core/gray4_checker.sv =====
// Port-level checks of the row packer and their binding to the top level.
`timescale 1ns / 1ps

module gray4_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [gray4_pkg::WORD_W-1:0]   rsp_out_word,
   input logic [gray4_pkg::COUNT_W-1:0]  rsp_byte_count,
   input logic                           rsp_is_command,
   input logic                           rsp_row_end,
   input logic                           rsp_area_end
);
   import gray4_pkg::*;

   // A stalled result transaction holds its word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_word))
      else $error("stalled result word changed");

   // The byte count always names one to four bytes.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_count != 3'd0 && rsp_byte_count <= FULL_COUNT)
      else $error("byte count out of range");

   // A command transaction is a full word that opens with the row address byte.
   a_cmd_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_command |->
         rsp_out_word[31:24] == CMD_ROW_ADDR && rsp_byte_count == FULL_COUNT &&
         !rsp_row_end && !rsp_area_end)
      else $error("malformed command transaction");

   // The end of the area is also the end of a row of data.
   a_area_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_area_end |-> rsp_row_end && !rsp_is_command)
      else $error("area end outside a row end");

   // The input is held off while a command transaction goes out.
   a_cmd_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_is_command |-> req_stall)
      else $error("input open while a row drains");

endmodule

bind rgb565_gray4_rotated_row_packer_core gray4_checker u_gray4_checker (.*);
